@@ sv/apc_pkg.sv @@
// ----------------------------------------------------------------------------
// apc_pkg
// shared types and constants for the array permutation check block
// ----------------------------------------------------------------------------
`default_nettype none

package apc_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CMD_W   = 2;

    // command codes of an input item
    localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK       = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic is_permutation;
        logic overflowed;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_LATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_TALLY,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic start;
        logic key_rd;
        logic key_latch;
        logic scan_rd;
        logic next_key;
        logic fail;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic counts_equal;
        logic count_zero;
        logic key_last;
        logic scan_last;
        logic occ_equal;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

@@ sv/array_permutation_check.sv @@
// ----------------------------------------------------------------------------
// array_permutation_check
// loads two arrays of signed words and checks whether the second is a
// permutation of the first (equal length, equal occurrence counts)
// ----------------------------------------------------------------------------
//
// channel   | signals                               | payload
// ----------+---------------------------------------+------------------------
// item      | item_valid, item_stall, item          | command, value
// result    | result_valid, result_stall, result    | is_permutation, overflowed
//
// a load leaves the block idle and the next item is taken in the next cycle
// a check walks each key of the first array through a key read, latch, scan of
// both stores, drain and tally, and ends early when the occurrence counts of a
// key differ; the first store has one read port, shared by key and scan reads;
// a length mismatch or both arrays empty skip the scan; item_stall stays high
// for the whole check; a pending result does not block loads, a new check waits
// at its end until the result register is free; reset clears fill counts,
// overflow flag and the result valid flag; the stores need no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module array_permutation_check #(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire apc_pkg::in_item_t  item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output apc_pkg::out_item_t      result
);

    // command and status between sequencer and datapath
    apc_pkg::ctrl_cmd_t    cmd;
    apc_pkg::ctrl_status_t status;

    // sequencer: takes items, walks the outer key loop and the inner scan
    apc_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .command    (item.command),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    // datapath: both stores, counts, occurrence counters, result register
    apc_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ sv/apc_ram.sv @@
// ----------------------------------------------------------------------------
// apc_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module apc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                         clk,
    input  wire logic                                         wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                             wr_data,
    input  wire logic                                         rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/apc_datapath.sv @@
// ----------------------------------------------------------------------------
// apc_datapath
// element stores, fill counts, occurrence counters and result register
// ----------------------------------------------------------------------------
`default_nettype none

module apc_datapath #(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire apc_pkg::in_item_t    item,
    input  wire apc_pkg::ctrl_cmd_t   cmd,
    output apc_pkg::ctrl_status_t     status,
    input  wire logic                 result_stall,
    output logic                      result_valid,
    output apc_pkg::out_item_t        result
);

    localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_ELEMENTS);

    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic          overflow_reg, overflow_next;
    logic [AW-1:0] idx_i_reg, idx_i_next;
    logic [AW-1:0] idx_j_reg, idx_j_next;
    logic [CW-1:0] occ_a_reg, occ_a_next;
    logic [CW-1:0] occ_b_reg, occ_b_next;
    logic          scan_v_reg, scan_v_next;
    logic          verdict_reg, verdict_next;
    logic          result_valid_reg, result_valid_next;
    logic [apc_pkg::VALUE_W-1:0] key_reg, key_next;
    apc_pkg::out_item_t          result_reg, result_next;

    logic                        wr_a, wr_b, rd_a;
    logic [AW-1:0]               rd_addr_a;
    logic [apc_pkg::VALUE_W-1:0] rd_data_a, rd_data_b;
    logic                        hit_a, hit_b;

    assign wr_a      = cmd.load_first  && (count_a_reg != FULL);
    assign wr_b      = cmd.load_second && (count_b_reg != FULL);
    assign rd_a      = cmd.key_rd || cmd.scan_rd;
    assign rd_addr_a = cmd.key_rd ? idx_i_reg : idx_j_reg;

    apc_ram #(
        .WIDTH (apc_pkg::VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram_first (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (count_a_reg[AW-1:0]),
        .wr_data (item.value),
        .rd_en   (rd_a),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    apc_ram #(
        .WIDTH (apc_pkg::VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram_second (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (count_b_reg[AW-1:0]),
        .wr_data (item.value),
        .rd_en   (cmd.scan_rd),
        .rd_addr (idx_j_reg),
        .rd_data (rd_data_b)
    );

    assign hit_a = (rd_data_a == key_reg);
    assign hit_b = (rd_data_b == key_reg);

    always_comb
    begin
        count_a_next      = count_a_reg;
        count_b_next      = count_b_reg;
        overflow_next     = overflow_reg;
        idx_i_next        = idx_i_reg;
        idx_j_next        = idx_j_reg;
        occ_a_next        = occ_a_reg;
        occ_b_next        = occ_b_reg;
        verdict_next      = verdict_reg;
        key_next          = key_reg;
        result_next       = result_reg;
        scan_v_next       = cmd.scan_rd;
        result_valid_next = result_valid_reg && result_stall;

        if (cmd.load_first)
        begin
            if (wr_a)
                count_a_next = count_a_reg + CW'(1);
            else
                overflow_next = 1'b1;
        end
        if (cmd.load_second)
        begin
            if (wr_b)
                count_b_next = count_b_reg + CW'(1);
            else
                overflow_next = 1'b1;
        end
        if (cmd.start)
        begin
            verdict_next = (count_a_reg == count_b_reg);
            idx_i_next   = '0;
        end
        if (cmd.key_latch)
        begin
            key_next   = rd_data_a;
            idx_j_next = '0;
            occ_a_next = '0;
            occ_b_next = '0;
        end
        if (cmd.scan_rd)
        begin
            idx_j_next = idx_j_reg + AW'(1);
        end
        // read data arrives in the cycle after its address
        if (scan_v_reg)
        begin
            occ_a_next = occ_a_reg + CW'(hit_a);
            occ_b_next = occ_b_reg + CW'(hit_b);
        end
        if (cmd.next_key)
        begin
            idx_i_next = idx_i_reg + AW'(1);
        end
        if (cmd.fail)
        begin
            verdict_next = 1'b0;
        end
        if (cmd.emit)
        begin
            result_next.is_permutation = verdict_reg;
            result_next.overflowed     = overflow_reg;
            result_valid_next          = 1'b1;
            count_a_next               = '0;
            count_b_next               = '0;
            overflow_next              = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg      <= '0;
            count_b_reg      <= '0;
            overflow_reg     <= 1'b0;
            idx_i_reg        <= '0;
            idx_j_reg        <= '0;
            occ_a_reg        <= '0;
            occ_b_reg        <= '0;
            scan_v_reg       <= 1'b0;
            verdict_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_a_reg      <= count_a_next;
            count_b_reg      <= count_b_next;
            overflow_reg     <= overflow_next;
            idx_i_reg        <= idx_i_next;
            idx_j_reg        <= idx_j_next;
            occ_a_reg        <= occ_a_next;
            occ_b_reg        <= occ_b_next;
            scan_v_reg       <= scan_v_next;
            verdict_reg      <= verdict_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    assign status.counts_equal = (count_a_reg == count_b_reg);
    assign status.count_zero   = (count_a_reg == '0);
    assign status.key_last     = (CW'(idx_i_reg) == count_a_reg - CW'(1));
    assign status.scan_last    = (CW'(idx_j_reg) == count_a_reg - CW'(1));
    assign status.occ_equal    = (occ_a_reg == occ_b_reg);
    assign status.out_free     = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

@@ sv/apc_controller.sv @@
// ----------------------------------------------------------------------------
// apc_controller
// sequencer for loads and the nested occurrence scan of a check
// ----------------------------------------------------------------------------
`default_nettype none

module apc_controller (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    input  wire logic [apc_pkg::CMD_W-1:0]   command,
    input  wire apc_pkg::ctrl_status_t       status,
    output logic                             item_stall,
    output apc_pkg::ctrl_cmd_t               cmd
);

    apc_pkg::state_t state_reg, state_next;
    logic            accept;

    assign accept = item_valid && (state_reg == apc_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            apc_pkg::ST_IDLE:
            begin
                if (accept && command == apc_pkg::CMD_CHECK)
                begin
                    if (!status.counts_equal || status.count_zero)
                        state_next = apc_pkg::ST_RESULT;
                    else
                        state_next = apc_pkg::ST_KEY;
                end
            end
            apc_pkg::ST_KEY:   state_next = apc_pkg::ST_LATCH;
            apc_pkg::ST_LATCH: state_next = apc_pkg::ST_SCAN;
            apc_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                    state_next = apc_pkg::ST_DRAIN;
            end
            apc_pkg::ST_DRAIN: state_next = apc_pkg::ST_TALLY;
            apc_pkg::ST_TALLY:
            begin
                if (!status.occ_equal || status.key_last)
                    state_next = apc_pkg::ST_RESULT;
                else
                    state_next = apc_pkg::ST_KEY;
            end
            apc_pkg::ST_RESULT:
            begin
                if (status.out_free)
                    state_next = apc_pkg::ST_IDLE;
            end
            default: state_next = apc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = (state_reg != apc_pkg::ST_IDLE);
        case (state_reg)
            apc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        apc_pkg::CMD_LOAD_FIRST:  cmd.load_first  = 1'b1;
                        apc_pkg::CMD_LOAD_SECOND: cmd.load_second = 1'b1;
                        apc_pkg::CMD_CHECK:       cmd.start       = 1'b1;
                        default:                  cmd             = '0;
                    endcase
                end
            end
            apc_pkg::ST_KEY:   cmd.key_rd    = 1'b1;
            apc_pkg::ST_LATCH: cmd.key_latch = 1'b1;
            apc_pkg::ST_SCAN:  cmd.scan_rd   = 1'b1;
            apc_pkg::ST_DRAIN: cmd           = '0;
            apc_pkg::ST_TALLY:
            begin
                if (!status.occ_equal)
                    cmd.fail = 1'b1;
                else if (!status.key_last)
                    cmd.next_key = 1'b1;
            end
            apc_pkg::ST_RESULT: cmd.emit = status.out_free;
            default:            cmd      = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= apc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ sv/apc_checker.sv @@
// ----------------------------------------------------------------------------
// apc_checker
// port-level properties of the array permutation check block
// ----------------------------------------------------------------------------
`default_nettype none

module apc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire apc_pkg::in_item_t  item,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire apc_pkg::out_item_t result
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // a check keeps the item side busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.command == apc_pkg::CMD_CHECK |=> item_stall)
        else $error("check transfer did not busy the block");

    // a load leaves the block ready for the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall &&
        (item.command == apc_pkg::CMD_LOAD_FIRST ||
         item.command == apc_pkg::CMD_LOAD_SECOND) |=> !item_stall)
        else $error("load transfer stalled the block");

    // a new result only comes out of a check in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared without a check");

endmodule

bind array_permutation_check apc_checker u_apc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
